// ===== hw/rtl/sfl_alloc_pkg.sv =====
`default_nettype none

package sfl_alloc_pkg;

   localparam int FRAME_W = 10;
   localparam int LINK_W  = 11;
   localparam int CSR_W   = 1;

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   localparam logic [CSR_W-1:0] CSR_FIRST_FRAME = 1'b0;
   localparam logic [CSR_W-1:0] CSR_END_FRAME   = 1'b1;

   typedef struct packed {
      logic [FRAME_W-1:0] first_frame;
      logic [LINK_W-1:0]  limit;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [LINK_W-1:0] frame;
      logic              oom;
   } done_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_free_list_page_allocator.sv =====
`default_nettype none

// Page frame allocator keeping free frames as an address-ordered linked list, one
// next-frame link per frame in a single-port-read, single-port-write RAM with a
// registered read. One item is worked at a time; a finished result sits in an
// output register so the next item can be taken while it waits. The RAM does one
// link access per cycle: init writes one link per frame from first_frame up to the
// limit; allocate reads the head's link unless out of memory; free below the head
// writes one link, and a free out of range or of the head is ignored; free in order
// reads links along the list (at most NUM_FRAMES), plus two writes when the frame is
// spliced in; no-op touches no link. A second finished item waits in its done state
// while the output register is still held. limit is min(end_frame, NUM_FRAMES, 2047).
// Links are undefined until init; there is no clearing pass after reset.
module sorted_free_list_page_allocator
   import sfl_alloc_pkg::*;
#(
   parameter int unsigned NUM_FRAMES = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [FRAME_W-1:0] req_frame_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [LINK_W-1:0]       rsp_frame_out,
   output logic                    rsp_out_of_memory,
   input  wire logic               csr_wr_en,
   input  wire logic [CSR_W-1:0]   csr_index,
   input  wire logic [LINK_W-1:0]  csr_wdata
);

   localparam int unsigned ADDR_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int unsigned LIM_CAP = (NUM_FRAMES < 2047) ? NUM_FRAMES : 2047;
   localparam logic [LINK_W-1:0] LIM_CAP_L = LINK_W'(LIM_CAP);

   logic [FRAME_W-1:0] first_frame_ff, first_frame_in;
   logic [LINK_W-1:0]  end_frame_ff, end_frame_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LINK_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic               rsp_oom_ff, rsp_oom_in;

   cfg_type            cfg;
   done_type           done;
   logic               slot_free;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [LINK_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [LINK_W-1:0]  mem_rd_data;

   always_comb begin
      first_frame_in = first_frame_ff;
      end_frame_in   = end_frame_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_FRAME: first_frame_in = csr_wdata[FRAME_W-1:0];
            CSR_END_FRAME:   end_frame_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.first_frame = first_frame_ff;
   assign cfg.limit       = (end_frame_ff < LIM_CAP_L) ? end_frame_ff : LIM_CAP_L;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_oom_in   = rsp_oom_ff;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = done.frame;
         rsp_oom_in   = done.oom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_frame_ff <= '0;
         end_frame_ff   <= LINK_W'(1024);
         rsp_valid_ff   <= 1'b0;
      end else begin
         first_frame_ff <= first_frame_in;
         end_frame_ff   <= end_frame_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_ff <= rsp_frame_in;
      rsp_oom_ff   <= rsp_oom_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_out     = rsp_frame_ff;
   assign rsp_out_of_memory = rsp_oom_ff;

   sfl_ctrl #(
      .NUM_FRAMES (NUM_FRAMES),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_frame_in (req_frame_in),
      .slot_free    (slot_free),
      .done         (done),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   sfl_link_ram #(
      .DEPTH  (NUM_FRAMES),
      .ADDR_W (ADDR_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // a finished item never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> slot_free)
      else $error("result register overwritten");

   // an accepted item keeps the block busy in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item in flight");

   // an out-of-memory result reports a head at or past the limit
   a_oom_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_memory) |-> (rsp_frame_out >= cfg.limit))
      else $error("out_of_memory with head inside range");

endmodule

`default_nettype wire

// ===== hw/rtl/sfl_link_ram.sv =====
`default_nettype none

module sfl_link_ram
   import sfl_alloc_pkg::*;
#(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [LINK_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [LINK_W-1:0] rd_data
);

   logic [LINK_W-1:0] link_mem_ff [DEPTH];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sfl_ctrl.sv =====
`default_nettype none

module sfl_ctrl
   import sfl_alloc_pkg::*;
#(
   parameter int unsigned NUM_FRAMES = 1024,
   parameter int unsigned ADDR_W     = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [FRAME_W-1:0] req_frame_in,
   input  wire logic               slot_free,
   output done_type                done,
   output logic                    mem_wr_en,
   output logic [ADDR_W-1:0]       mem_wr_addr,
   output logic [LINK_W-1:0]       mem_wr_data,
   output logic                    mem_rd_en,
   output logic [ADDR_W-1:0]       mem_rd_addr,
   input  wire logic [LINK_W-1:0]  mem_rd_data
);

   localparam int unsigned EXT_W = (ADDR_W > LINK_W) ? ADDR_W : LINK_W;
   localparam logic [ADDR_W-1:0] LAST_STEP = ADDR_W'(NUM_FRAMES - 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_INIT  = 6'b000010,
      ST_ALLOC = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_LINK  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] target_ff, target_in;
   logic [LINK_W-1:0] nxt_ff, nxt_in;
   logic [ADDR_W-1:0] steps_ff, steps_in;
   logic [LINK_W-1:0] res_frame_ff, res_frame_in;
   logic              res_oom_ff, res_oom_in;
   logic [LINK_W-1:0] req_frame;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [LINK_W-1:0] v);
      logic [EXT_W-1:0] e;
      e = EXT_W'(v);
      return e[ADDR_W-1:0];
   endfunction

   assign req_frame = {1'b0, req_frame_in};
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      target_in    = target_ff;
      nxt_in       = nxt_ff;
      steps_in     = steps_ff;
      res_frame_in = res_frame_ff;
      res_oom_in   = res_oom_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = to_addr(cur_ff);
      mem_wr_data  = cur_ff + LINK_W'(1);
      mem_rd_en    = 1'b0;
      mem_rd_addr  = to_addr(head_ff);
      done.valid   = 1'b0;
      done.frame   = res_frame_ff;
      done.oom     = res_oom_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_frame_in = '0;
               res_oom_in   = 1'b0;
               state_in     = ST_DONE;
               unique case (cmd_type'(req_command))
                  CMD_INIT: begin
                     head_in  = {1'b0, cfg.first_frame};
                     cur_in   = {1'b0, cfg.first_frame};
                     state_in = ST_INIT;
                  end
                  CMD_ALLOC: begin
                     res_frame_in = head_ff;
                     if (head_ff < cfg.limit) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_ALLOC;
                     end else begin
                        res_oom_in = 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (req_frame >= cfg.limit || req_frame == head_ff) begin
                        // out of range or double free of the head: ignored
                     end else if (req_frame < head_ff) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = to_addr(req_frame);
                        mem_wr_data = head_ff;
                        head_in     = req_frame;
                     end else begin
                        mem_rd_en = 1'b1;
                        cur_in    = head_ff;
                        target_in = req_frame;
                        steps_in  = '0;
                        state_in  = ST_WALK;
                     end
                  end
                  CMD_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            if (cur_ff < cfg.limit) begin
               mem_wr_en = 1'b1;
               cur_in    = cur_ff + LINK_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ALLOC: begin
            head_in  = mem_rd_data;
            state_in = ST_DONE;
         end
         ST_WALK: begin
            if (mem_rd_data == target_ff) begin
               state_in = ST_DONE;
            end else if (mem_rd_data > target_ff) begin
               // splice: cur -> target now, target -> old next in ST_LINK
               mem_wr_en   = 1'b1;
               mem_wr_data = target_ff;
               nxt_in      = mem_rd_data;
               state_in    = ST_LINK;
            end else begin
               cur_in = mem_rd_data;
               if (steps_ff == LAST_STEP) begin
                  state_in = ST_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = to_addr(mem_rd_data);
                  steps_in    = steps_ff + ADDR_W'(1);
               end
            end
         end
         ST_LINK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = to_addr(target_ff);
            mem_wr_data = nxt_ff;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               done.valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      target_ff    <= target_in;
      nxt_ff       <= nxt_in;
      steps_ff     <= steps_in;
      res_frame_ff <= res_frame_in;
      res_oom_ff   <= res_oom_in;
   end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sfl_alloc_pkg::*;

   localparam int NUM_FRAMES   = 1024;
   localparam int TOTAL_ITEMS  = 550;
   localparam int STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 4000000;

   typedef struct packed {
      logic [LINK_W-1:0] frame;
      logic              oom;
   } frame_grant_type;

   typedef struct packed {
      logic               is_csr;
      logic [CSR_W-1:0]   csr_idx;
      logic [LINK_W-1:0]  csr_val;
      cmd_type            cmd;
      logic [FRAME_W-1:0] frame;
      logic               typed;
      logic [LINK_W-1:0]  exp_frame;
      logic               exp_oom;
   } step_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   cmd_type            req_command = CMD_NOP;
   logic [FRAME_W-1:0] req_frame_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [LINK_W-1:0]  rsp_frame_out;
   logic               rsp_out_of_memory;
   logic               csr_wr_en = 1'b0;
   logic [CSR_W-1:0]   csr_index = CSR_FIRST_FRAME;
   logic [LINK_W-1:0]  csr_wdata = '0;

   // allocator mirror
   logic [FRAME_W-1:0] cfg_first = '0;
   logic [LINK_W-1:0]  cfg_end = LINK_W'(1024);
   logic [LINK_W-1:0]  free_head = '0;
   logic [LINK_W-1:0]  succ [NUM_FRAMES];

   frame_grant_type    expected_grants[$];
   int                 errors = 0;
   int                 items_sent = 0;
   int                 cycle_count = 0;
   int                 send_idle_pct = 37;
   int                 rcv_idle_pct = 77;
   int                 hold_asked = 0;
   int                 hold_served = 0;
   int                 hold_left = 0;

   sorted_free_list_page_allocator #(
      .NUM_FRAMES(NUM_FRAMES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_frame_in      (req_frame_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_out     (rsp_frame_out),
      .rsp_out_of_memory (rsp_out_of_memory),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random back-pressure plus one long hold on request
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left <= STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      frame_grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected item, frame_out %0d oom %0b", $time,
                     rsp_frame_out, rsp_out_of_memory);
            errors++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_frame_out !== want.frame) begin
               $display("%0t: frame_out mismatch, expected %0d, actual %0d", $time,
                        want.frame, rsp_frame_out);
               errors++;
            end
            if (rsp_out_of_memory !== want.oom) begin
               $display("%0t: out_of_memory mismatch, expected %0b, actual %0b", $time,
                        want.oom, rsp_out_of_memory);
               errors++;
            end
         end
      end
   end

   task automatic run_allocator(input cmd_type cmd, input logic [FRAME_W-1:0] frame,
                                output frame_grant_type res);
      logic [LINK_W-1:0] lim;
      logic [LINK_W-1:0] p;
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] nxt;
      int                steps;
      bit                done;
      lim = (cfg_end < NUM_FRAMES) ? cfg_end : LINK_W'(NUM_FRAMES);
      p = {1'b0, frame};
      res.frame = '0;
      res.oom = 1'b0;
      case (cmd)
         CMD_INIT: begin
            for (int f = int'(cfg_first); f < int'(lim); f++)
               succ[f] = LINK_W'(f + 1);
            free_head = {1'b0, cfg_first};
         end
         CMD_ALLOC: begin
            res.frame = free_head;
            if (free_head < lim)
               free_head = succ[free_head[FRAME_W-1:0]];
            else
               res.oom = 1'b1;
         end
         CMD_FREE: begin
            if (p < lim && p != free_head) begin
               if (p < free_head) begin
                  succ[frame] = free_head;
                  free_head = p;
               end else begin
                  // ordered insert; cur stays below p throughout the walk
                  cur = free_head;
                  steps = 0;
                  done = 1'b0;
                  while (!done && steps < NUM_FRAMES) begin
                     nxt = succ[cur[FRAME_W-1:0]];
                     if (nxt == p) begin
                        done = 1'b1;
                     end else if (nxt > p) begin
                        succ[cur[FRAME_W-1:0]] = p;
                        succ[frame] = nxt;
                        done = 1'b1;
                     end else begin
                        cur = nxt;
                     end
                     steps++;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_command(input cmd_type cmd, input logic [FRAME_W-1:0] frame,
                               input bit typed, input frame_grant_type typed_res,
                               output frame_grant_type res);
      int gaps;
      gaps = 0;
      while ($urandom_range(99) < send_idle_pct)
         gaps++;
      csr_wr_en <= 1'b0;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_frame_in <= frame;
      do @(posedge clock); while (!req_ready);
      run_allocator(cmd, frame, res);
      if (typed)
         expected_grants.push_back(typed_res);
      else
         expected_grants.push_back(res);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_grants.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_W-1:0] idx, input logic [LINK_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_FIRST_FRAME)
         cfg_first = val[FRAME_W-1:0];
      else
         cfg_end = val;
   endtask

   function automatic step_row_type csr_row(input logic [CSR_W-1:0] idx,
                                            input logic [LINK_W-1:0] val);
      step_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      r.cmd = CMD_NOP;
      return r;
   endfunction

   function automatic step_row_type cmd_row(input cmd_type cmd,
                                            input logic [FRAME_W-1:0] frame,
                                            input logic typed,
                                            input logic [LINK_W-1:0] exp_frame,
                                            input logic exp_oom);
      step_row_type r;
      r = '0;
      r.cmd = cmd;
      r.frame = frame;
      r.typed = typed;
      r.exp_frame = exp_frame;
      r.exp_oom = exp_oom;
      return r;
   endfunction

   initial begin
      step_row_type       directed_rows[$];
      step_row_type       row;
      frame_grant_type    typed_res;
      frame_grant_type    res;
      logic [FRAME_W-1:0] granted[$];
      logic [FRAME_W-1:0] pick;
      cmd_type            cmd;
      int                 first_v;
      int                 end_v;
      int                 n;
      int                 r;
      int                 k;
      bit                 hold_done;

      hold_done = 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++)
         succ[i] = '0;

      // reset config: full range, every link gets written by the first init
      directed_rows.push_back(cmd_row(CMD_INIT,  10'd0,    1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0,    1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd1023, 1'b1, 11'd1, 1'b0));
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd0,    1'b1, 11'd0, 1'b0));
      // already on the list, found only after a full-length walk
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd1023, 1'b0, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_NOP,   10'd1023, 1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0,    1'b1, 11'd0, 1'b0));
      // two-frame range: exhaust, then refill below head and below first_frame
      directed_rows.push_back(csr_row(CSR_FIRST_FRAME, 11'd3));
      directed_rows.push_back(csr_row(CSR_END_FRAME,   11'd5));
      directed_rows.push_back(cmd_row(CMD_INIT,  10'd0, 1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b1, 11'd3, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b1, 11'd4, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b1, 11'd5, 1'b1));
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd4, 1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd4, 1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd7, 1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd2, 1'b1, 11'd0, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b1, 11'd2, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b0, 11'd0, 1'b0));
      // empty range
      directed_rows.push_back(csr_row(CSR_FIRST_FRAME, 11'd1023));
      directed_rows.push_back(csr_row(CSR_END_FRAME,   11'd0));
      directed_rows.push_back(cmd_row(CMD_INIT,  10'd0, 1'b1, 11'd0,    1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b1, 11'd1023, 1'b1));
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd0, 1'b1, 11'd0,    1'b0));
      // single top frame
      directed_rows.push_back(csr_row(CSR_END_FRAME, 11'd1024));
      directed_rows.push_back(cmd_row(CMD_INIT,  10'd0, 1'b1, 11'd0,    1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b1, 11'd1023, 1'b0));
      directed_rows.push_back(cmd_row(CMD_ALLOC, 10'd0, 1'b1, 11'd1024, 1'b1));
      directed_rows.push_back(cmd_row(CMD_FREE,  10'd1023, 1'b0, 11'd0, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            wait_idle();
            csr_write(row.csr_idx, row.csr_val);
         end else begin
            typed_res.frame = row.exp_frame;
            typed_res.oom = row.exp_oom;
            send_command(row.cmd, row.frame, row.typed, typed_res, res);
         end
      end

      while (items_sent < TOTAL_ITEMS) begin
         wait_idle();
         r = $urandom_range(99);
         if (r < 10) begin
            first_v = 0;
            end_v = 1024;
         end else if (r < 18) begin
            first_v = $urandom_range(1023);
            end_v = $urandom_range(first_v);
         end else if (r < 28) begin
            first_v = 1023 - $urandom_range(15);
            end_v = 1024 - $urandom_range(1);
         end else begin
            first_v = $urandom_range(1000);
            end_v = first_v + 1 + $urandom_range(23);
         end
         if ($urandom_range(4) != 0)
            csr_write(CSR_FIRST_FRAME, LINK_W'(first_v));
         csr_write(CSR_END_FRAME, LINK_W'(end_v));
         // now and then keep the old chain against the new limits
         if ($urandom_range(9) != 0) begin
            send_command(CMD_INIT, FRAME_W'($urandom_range(1023)), 1'b0, '0, res);
            granted.delete();
         end
         n = $urandom_range(55, 25);
         for (int j = 0; j < n && items_sent < TOTAL_ITEMS; j++) begin
            if (items_sent < 200) begin
               send_idle_pct = 37;
               rcv_idle_pct = 77;
            end else if (items_sent < 380) begin
               send_idle_pct = 77;
               rcv_idle_pct = 37;
            end else begin
               send_idle_pct = 0;
               rcv_idle_pct = 0;
            end
            if (!hold_done && items_sent >= 80) begin
               hold_asked <= hold_asked + 1;
               hold_done = 1'b1;
            end
            pick = FRAME_W'($urandom_range(1023));
            r = $urandom_range(99);
            if (r < 45) begin
               cmd = CMD_ALLOC;
            end else if (r < 80 && granted.size() > 0) begin
               cmd = CMD_FREE;
               k = $urandom_range(granted.size() - 1);
               pick = granted[k];
               granted.delete(k);
            end else if (r < 80) begin
               cmd = CMD_ALLOC;
            end else if (r < 87) begin
               cmd = CMD_FREE;
            end else if (r < 93) begin
               cmd = CMD_FREE;
               k = int'(cfg_first) + $urandom_range(24);
               pick = (k > 1023) ? FRAME_W'(1023) : FRAME_W'(k);
            end else if (r < 97) begin
               cmd = CMD_NOP;
            end else begin
               cmd = CMD_INIT;
            end
            send_command(cmd, pick, 1'b0, '0, res);
            if (cmd == CMD_INIT)
               granted.delete();
            else if (cmd == CMD_ALLOC && !res.oom)
               granted.push_back(res.frame[FRAME_W-1:0]);
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sfl_alloc_pkg.sv
hw/rtl/sfl_link_ram.sv
hw/rtl/sfl_ctrl.sv
hw/rtl/sorted_free_list_page_allocator.sv
verif/tb.sv
